>>> rtl/dtic_pkg.sv
// ---------------------------------------------------------------------------
// dtic_pkg : shared types and constants for the in-circle check unit
// Point store size, coordinate width, payload structs and cell handover.
// ---------------------------------------------------------------------------
`default_nettype none
package dtic_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = 11;
  localparam int DIF_BITS   = COORD_BITS + 1;        // difference
  localparam int SQ_BITS    = 2 * DIF_BITS + 1;      // squared length sum
  localparam int P2_BITS    = DIF_BITS + SQ_BITS;    // minor product
  localparam int M_BITS     = P2_BITS + 1;           // minor
  localparam int T_BITS     = SQ_BITS + M_BITS;      // term
  localparam int DET_BITS   = T_BITS + 2;            // determinant
  localparam int NUM_CELLS  = 5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  typedef struct packed {
    logic                         func;
    logic [9:0]                   point_index;
    logic signed [15:0]           point_x;
    logic signed [15:0]           point_y;
    logic [9:0]                   vert_a;
    logic [9:0]                   vert_b;
    logic [9:0]                   vert_c;
  } in_item_t;

  typedef struct packed {
    logic is_delaunay;
    logic bad_index;
  } out_item_t;

  // Data handed from one cell to the next each cycle.
  typedef struct packed {
    logic                        vld;
    logic signed [DIF_BITS-1:0]  e0, e1, e3, e4, e6, e7;
    logic signed [SQ_BITS-1:0]   s0, s1, s2;
    logic signed [M_BITS-1:0]    m0, m1, m2;
    logic signed [DET_BITS-1:0]  acc;
  } cell_bus_t;
endpackage
`default_nettype wire

>>> rtl/dtic_cell.sv
// ---------------------------------------------------------------------------
// dtic_cell : one step of the in-circle determinant chain
// Each cell does one group of products on the handed data and passes it on.
// ---------------------------------------------------------------------------
`default_nettype none
module dtic_cell import dtic_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [2:0] step,
  input  wire cell_bus_t  din,
  output cell_bus_t       dout
);
  cell_bus_t nxt;

  always_comb begin
    nxt = din;
    case (step)
      3'd0: begin  // squared lengths
        nxt.s0 = SQ_BITS'(din.e0 * din.e0) + SQ_BITS'(din.e1 * din.e1);
        nxt.s1 = SQ_BITS'(din.e3 * din.e3) + SQ_BITS'(din.e4 * din.e4);
        nxt.s2 = SQ_BITS'(din.e6 * din.e6) + SQ_BITS'(din.e7 * din.e7);
      end
      3'd1: begin  // 2x2 minors
        nxt.m0 = M_BITS'(din.e4 * din.s2) - M_BITS'(din.s1 * din.e7);
        nxt.m1 = M_BITS'(din.e3 * din.s2) - M_BITS'(din.s1 * din.e6);
        nxt.m2 = M_BITS'(din.e3 * din.e7) - M_BITS'(din.e4 * din.e6);
      end
      3'd2: nxt.acc = DET_BITS'(din.e0 * din.m0);
      3'd3: nxt.acc = din.acc - DET_BITS'(din.e1 * din.m1);
      // m2 is a difference of two coordinate products: fits SQ_BITS
      default: nxt.acc = din.acc + DET_BITS'(din.s0 * $signed(din.m2[SQ_BITS-1:0]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.e0 <= nxt.e0; dout.e1 <= nxt.e1; dout.e3 <= nxt.e3;
    dout.e4 <= nxt.e4; dout.e6 <= nxt.e6; dout.e7 <= nxt.e7;
    dout.s0 <= nxt.s0; dout.s1 <= nxt.s1; dout.s2 <= nxt.s2;
    dout.m0 <= nxt.m0; dout.m1 <= nxt.m1; dout.m2 <= nxt.m2;
    dout.acc <= nxt.acc;
  end
endmodule
`default_nettype wire

>>> rtl/delaunay_triangle_incircle_check_unit.sv
// ---------------------------------------------------------------------------
// delaunay_triangle_incircle_check_unit : Delaunay empty-circumcircle test
// Point store, vertex fetch sequencer and a chain of determinant cells.
// ---------------------------------------------------------------------------
// A write beat (func 0) stores one point; writes can follow back to back.
// A test beat (func 1) first reads the three vertices in turn through the
// one registered read port, orients the triangle with registered products,
// then streams each stored point below the count in effect (point_count,
// at most the store size) through the five-cell determinant chain, one
// point a cycle, then ends the sweep and drains the chain. busy is high
// from the accepting edge until the sweep and drain are done; the single
// read port of the point store sets the sweep rate. The result appears on
// the result ports with done high for exactly one cycle, the first cycle
// with busy low; there is no back-pressure, so the receiver must take it
// then. A bad vertex goes from the fetch state straight to the result
// with bad_index 1. point_count is written only while idle.
`default_nettype none
module delaunay_triangle_incircle_check_unit import dtic_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire in_item_t            in_item,
  output logic                     done,
  output out_item_t                out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CNT_BITS-1:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_FETCH = 3'd1, S_ORIENT = 3'd2,
                         S_SWEEP = 3'd3, S_DRAIN = 3'd4, S_DONE = 3'd5;
  localparam int LAT = NUM_CELLS + 2;

  logic [2:0]                 state;
  logic [CNT_BITS-1:0]        point_count;
  logic [CNT_BITS-1:0]        count;
  logic [IDX_BITS-1:0]        va, vb, vc;
  logic [1:0]                 fcnt;
  logic [CNT_BITS-1:0]        d;
  logic [3:0]                 drain;
  logic                       hit, bad;
  logic [COORD_BITS-1:0]      x_mem [MAX_POINTS];
  logic [COORD_BITS-1:0]      y_mem [MAX_POINTS];
  logic [IDX_BITS-1:0]        raddr;
  logic signed [COORD_BITS-1:0] rx, ry;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
  logic [IDX_BITS-1:0]        d_q;     // index of point being read
  logic                       rd_vld, d_skip;
  logic signed [2*DIF_BITS:0] orient;
  logic signed [2*DIF_BITS:0] op1, op2;
  logic                       op_vld;
  cell_bus_t                  bus [NUM_CELLS+1];

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign count     = (point_count > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS)
                                                           : point_count;

  // Store: one write, one registered read per cycle.
  always_comb begin
    case (state)
      S_FETCH: raddr = (fcnt == 2'd0) ? va : (fcnt == 2'd1) ? vb : vc;
      default: raddr = d[IDX_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy && in_item.func == FUNC_WRITE) begin
      x_mem[in_item.point_index] <= in_item.point_x[COORD_BITS-1:0];
      y_mem[in_item.point_index] <= in_item.point_y[COORD_BITS-1:0];
    end
    rx <= x_mem[raddr];
    ry <= y_mem[raddr];
  end

  // Orientation: products registered, then compared.
  always_ff @(posedge clk) begin
    op1 <= (2*DIF_BITS+1)'((DIF_BITS'(bx) - DIF_BITS'(ax)) * (DIF_BITS'(cy) - DIF_BITS'(ay)));
    op2 <= (2*DIF_BITS+1)'((DIF_BITS'(by) - DIF_BITS'(ay)) * (DIF_BITS'(cx) - DIF_BITS'(ax)));
  end
  assign orient = op1 - op2;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; point_count <= '0; done <= 1'b0;
      rd_vld <= 1'b0; op_vld <= 1'b0; hit <= 1'b0; bad <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= 1'b0;
      if (cfg_valid && cfg_ready) point_count <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start && in_item.func == FUNC_TEST) begin
            va <= in_item.vert_a; vb <= in_item.vert_b; vc <= in_item.vert_c;
            bad <= (CNT_BITS'(in_item.vert_a) >= count) ||
                   (CNT_BITS'(in_item.vert_b) >= count) ||
                   (CNT_BITS'(in_item.vert_c) >= count);
            fcnt <= '0; hit <= 1'b0; op_vld <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (bad) begin
            state <= S_DONE;
          end else begin
            fcnt <= fcnt + 2'd1;
            if (fcnt == 2'd1) begin ax <= rx; ay <= ry; end
            if (fcnt == 2'd2) begin bx <= rx; by <= ry; end
            if (fcnt == 2'd3) begin cx <= rx; cy <= ry; state <= S_ORIENT; end
          end
        end
        S_ORIENT: begin
          op_vld <= 1'b1;
          if (op_vld) begin
            if (orient <= 0) begin
              vb <= vc; vc <= vb; bx <= cx; by <= cy; cx <= bx; cy <= by;
            end
            d <= '0;
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (d >= count) begin
            drain <= 4'(LAT);
            state <= S_DRAIN;
          end else begin
            d_q    <= d[IDX_BITS-1:0];
            rd_vld <= 1'b1;
            d      <= d + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain == 4'd0) state <= S_DONE;
          else drain <= drain - 4'd1;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (bus[NUM_CELLS].vld && bus[NUM_CELLS].acc > 0) hit <= 1'b1;
    end
  end

  assign d_skip = (d_q == va) || (d_q == vb) || (d_q == vc);

  // Feed of the cell chain: differences against the streamed point.
  always_comb begin
    bus[0]     = '0;
    bus[0].vld = rd_vld && !d_skip;
    bus[0].e0  = DIF_BITS'(ax) - DIF_BITS'(rx);
    bus[0].e1  = DIF_BITS'(ay) - DIF_BITS'(ry);
    bus[0].e3  = DIF_BITS'(bx) - DIF_BITS'(rx);
    bus[0].e4  = DIF_BITS'(by) - DIF_BITS'(ry);
    bus[0].e6  = DIF_BITS'(cx) - DIF_BITS'(rx);
    bus[0].e7  = DIF_BITS'(cy) - DIF_BITS'(ry);
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    dtic_cell u_cell (
      .clk (clk), .rst (rst), .step (3'(g)),
      .din (bus[g]), .dout (bus[g+1])
    );
  end

  assign out_item.is_delaunay = !bad && !hit;
  assign out_item.bad_index   = bad;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    done && out_item.bad_index |-> !out_item.is_delaunay)
    else $error("bad index with delaunay set");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
endmodule
`default_nettype wire

>>> test/delaunay_triangle_incircle_check_unit_test.sv
// ---------------------------------------------------------------------------
// delaunay_triangle_incircle_check_unit_test : in-circle check unit testbench
// Drives point writes and triangle tests, predicts each verdict in the bench
// and compares every done beat with the oldest expected verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module delaunay_triangle_incircle_check_unit_test;
  import dtic_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_item = '0;
  logic                done;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_data = '0;

  delaunay_triangle_incircle_check_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the block's state
  logic signed [15:0]  px [MAX_POINTS];
  logic signed [15:0]  py [MAX_POINTS];
  bit                  written [MAX_POINTS];
  int unsigned         n_pts;
  out_item_t           verdicts_due [$];
  int                  n_errors = 0;
  int                  idle_pct = 0;

  // In-circle determinant, exact in 128-bit signed arithmetic
  function automatic bit in_circle(int ia, int ib, int ic, int id);
    logic signed [127:0] e0, e1, e3, e4, e6, e7, s0, s1, s2, det;
    e0 = px[ia] - px[id];  e1 = py[ia] - py[id];
    e3 = px[ib] - px[id];  e4 = py[ib] - py[id];
    e6 = px[ic] - px[id];  e7 = py[ic] - py[id];
    s0 = e0*e0 + e1*e1;  s1 = e3*e3 + e4*e4;  s2 = e6*e6 + e7*e7;
    det = e0*(e4*s2 - s1*e7) - e1*(e3*s2 - s1*e6) + s0*(e3*e7 - e4*e6);
    return det > 0;
  endfunction

  function automatic out_item_t triangle_verdict(int a, int b, int c);
    out_item_t r;
    longint orient;
    int t;
    int cnt;
    cnt = (n_pts < MAX_POINTS) ? n_pts : MAX_POINTS;
    if (a >= cnt || b >= cnt || c >= cnt) begin
      r.is_delaunay = 1'b0;
      r.bad_index = 1'b1;
      return r;
    end
    orient = (longint'(px[b]) - px[a]) * (longint'(py[c]) - py[a])
           - (longint'(py[b]) - py[a]) * (longint'(px[c]) - px[a]);
    if (orient <= 0) begin
      t = b; b = c; c = t;
    end
    r.is_delaunay = 1'b1;
    r.bad_index = 1'b0;
    for (int d = 0; d < cnt; d++) begin
      if (d != a && d != b && d != c && in_circle(a, b, c, d)) begin
        r.is_delaunay = 1'b0;
        break;
      end
    end
    return r;
  endfunction

  // Random idle cycles before a beat, per current idle percentage
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Send one beat; verdict predicted at acceptance. start stays high after
  // the accepting edge until the next beat, an idle cycle or a drain.
  task automatic send_beat(in_item_t it);
    idle_gap();
    start <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (it.func == FUNC_WRITE) begin
      px[it.point_index] = it.point_x;
      py[it.point_index] = it.point_y;
      written[it.point_index] = 1'b1;
    end else begin
      verdicts_due.push_back(triangle_verdict(int'(it.vert_a), int'(it.vert_b),
                                              int'(it.vert_c)));
    end
  endtask

  task automatic write_point(int idx, int x, int y);
    in_item_t it;
    it.func        = FUNC_WRITE;
    it.point_index = IDX_BITS'(idx);
    it.point_x     = 16'(x);
    it.point_y     = 16'(y);
    it.vert_a      = IDX_BITS'($urandom());  // noise in unused fields
    it.vert_b      = IDX_BITS'($urandom());
    it.vert_c      = IDX_BITS'($urandom());
    send_beat(it);
  endtask

  task automatic send_triangle(int a, int b, int c);
    in_item_t it;
    it.func        = FUNC_TEST;
    it.point_index = IDX_BITS'($urandom());
    it.point_x     = 16'($urandom());
    it.point_y     = 16'($urandom());
    it.vert_a      = IDX_BITS'(a);
    it.vert_b      = IDX_BITS'(b);
    it.vert_c      = IDX_BITS'(c);
    send_beat(it);
  endtask

  // Wait for every verdict, then latency slack, before touching config
  task automatic drain();
    start   <= 1'b0;
    in_item <= '0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_count(int n);
    cfg_valid <= 1'b1;
    cfg_data <= CNT_BITS'(n);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    n_pts = int'(n[CNT_BITS-1:0]);
  endtask

  // Picks a vertex below count; test_random writes every such entry first
  function automatic int pick_vertex(int cnt);
    return $urandom_range(cnt - 1);
  endfunction

  // Directed: extremes, both functions, bad vertex, repeats, zero count
  task automatic test_directed();
    set_count(0);
    send_triangle(0, 0, 0);                // zero count: bad vertex
    send_triangle(1023, 1023, 1023);
    write_point(0, -32768, -32768);
    write_point(1, 32767, -32768);
    write_point(2, 32767, 32767);
    write_point(3, -32768, 32767);
    write_point(4, 0, 0);                  // centre, strictly inside
    write_point(1023, -1, 1);
    drain();
    set_count(5);
    send_triangle(0, 1, 2);                // ccw, centre inside
    send_triangle(0, 2, 1);                // cw, swap
    send_triangle(0, 0, 1);                // repeated vertices
    send_triangle(4, 4, 4);
    send_triangle(0, 1, 5);                // bad vertex c
    send_triangle(5, 0, 1);
    send_triangle(0, 7, 1);
    write_point(4, 32767, 32767);          // cocircular duplicate, not strict
    drain();
    set_count(4);
    send_triangle(0, 1, 2);
    send_triangle(1, 2, 3);
    drain();
  endtask

  // Random: fill small sets, then test mostly valid triangles
  task automatic test_random(int rounds, int pct);
    int cnt;
    idle_pct = pct;
    for (int r = 0; r < rounds; r++) begin
      drain();
      cnt = (r % 9 == 8) ? $urandom_range(300, 1024) : $urandom_range(4, 24);
      set_count(cnt);
      for (int i = 0; i < cnt; i++) begin
        if (!written[i] || $urandom_range(3) == 0) begin
          if ($urandom_range(3) == 0)
            write_point(i, $urandom(), $urandom());
          else
            write_point(i, $urandom_range(64) - 32, $urandom_range(64) - 32);
        end
      end
      // large sets get few tests
      for (int k = 0; k < ((r % 9 == 8) ? 2 : 12); k++) begin
        if ($urandom_range(9) == 0)
          send_triangle($urandom(), $urandom(), $urandom());
        else
          send_triangle(pick_vertex(cnt), pick_vertex(cnt), pick_vertex(cnt));
      end
      if (r == 3) drain();  // sender holds until all verdicts are in
    end
    drain();
  endtask

  // Verdict checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
      end else begin
        automatic out_item_t exp_v = verdicts_due.pop_front();
        if (out_item.is_delaunay !== exp_v.is_delaunay) begin
          $error("is_delaunay: expected %0b, got %0b", exp_v.is_delaunay,
                 out_item.is_delaunay);
          n_errors++;
        end
        if (out_item.bad_index !== exp_v.bad_index) begin
          $error("bad_index: expected %0b, got %0b", exp_v.bad_index,
                 out_item.bad_index);
          n_errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(8, 0);
    test_random(8, 62);
    test_random(8, 22);
    test_random(6, 0);
    drain();
    if (n_errors == 0 && verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> filelist.f
rtl/dtic_pkg.sv
rtl/dtic_cell.sv
rtl/delaunay_triangle_incircle_check_unit.sv
test/delaunay_triangle_incircle_check_unit_test.sv
